[src/ffid_pkg.sv]
// ----------------------------------------------------------------------------
// ffid_pkg
// Types, constants and codes shared by the free-fall and impact detector.
// ----------------------------------------------------------------------------
package ffid_pkg;

   // log ring and sample timing
   localparam int LOG_SLOTS  = 16;
   localparam int SLOT_W     = 4;
   localparam int COUNT_W    = 5;
   localparam int TICK_MS    = 10;

   // sequencing
   localparam int AXES       = 3;
   localparam int ROOT_STEPS = 16;
   localparam int CNT_W      = $clog2(ROOT_STEPS);

   // stream widths
   localparam int REQ_W      = 80;
   localparam int RSP_W      = 192;
   localparam int CSR_AW     = 5;
   localparam int CSR_DW     = 32;

   // register map, index into paddr[4:2]
   localparam logic [2:0] REG_FALL_THR   = 3'd0;
   localparam logic [2:0] REG_IMPACT_THR = 3'd1;
   localparam logic [2:0] REG_FALL_MIN   = 3'd2;
   localparam logic [2:0] REG_WINDOW     = 3'd3;
   localparam logic [2:0] REG_BEEP       = 3'd4;

   // register reset values
   localparam logic [31:0] FALL_THR_RST   = 32'd24159191;
   localparam logic [31:0] IMPACT_THR_RST = 32'd1073741824;
   localparam logic [15:0] FALL_MIN_RST   = 16'd80;
   localparam logic [15:0] WINDOW_RST     = 16'd500;
   localparam logic [15:0] BEEP_RST       = 16'd200;

   // squarer operand select
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_FALLING = 2'd1,
      PH_IMPACT  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_FALL   = 2'd1,
      EV_IMPACT = 2'd2
   } event_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_CLEAR,
      CS_SQUARE,
      CS_EVAL,
      CS_ROOT,
      CS_FINISH,
      CS_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic [31:0] fall_thr;
      logic [31:0] impact_thr;
      logic [15:0] fall_min;
      logic [15:0] window;
      logic [15:0] beep;
   } cfg_type;

   typedef struct packed {
      logic       capture;
      logic       clear;
      logic       sq_step;
      logic [1:0] axis;
      logic       eval;
      logic       root_step;
      logic       root_done;
      logic       load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic impact;
   } dp_sts_type;

endpackage

[src/ffid_ctrl.sv]
// ----------------------------------------------------------------------------
// ffid_ctrl
// Sequencer: takes a request, runs a clear or the squarer, the update step
// and on an impact the square root, then hands the result to the output register.
// ----------------------------------------------------------------------------
module ffid_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output ffid_pkg::dp_cmd_type  cmd,
   input  ffid_pkg::dp_sts_type  sts
);
   import ffid_pkg::*;

   ctrl_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             out_valid_ff, out_valid_in;
   logic             load;

   assign load = (state_ff == CS_DONE) && (!out_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         CS_IDLE: begin
            cnt_in = '0;
            if (req_tvalid) begin
               state_in = req_tuser ? CS_CLEAR : CS_SQUARE;
            end
         end
         CS_CLEAR: begin
            state_in = CS_DONE;
         end
         CS_SQUARE: begin
            if (cnt_ff == CNT_W'(AXES - 1)) begin
               cnt_in   = '0;
               state_in = CS_EVAL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         CS_EVAL: begin
            state_in = sts.impact ? CS_ROOT : CS_DONE;
         end
         CS_ROOT: begin
            if (cnt_ff == CNT_W'(ROOT_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = CS_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         CS_FINISH: begin
            state_in = CS_DONE;
         end
         CS_DONE: begin
            if (load) begin
               out_valid_in = 1'b1;
               state_in     = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd           = '0;
      req_tready    = 1'b0;
      cmd.axis      = cnt_ff[1:0];
      cmd.load_out  = load;
      case (state_ff)
         CS_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         CS_CLEAR:  cmd.clear     = 1'b1;
         CS_SQUARE: cmd.sq_step   = 1'b1;
         CS_EVAL:   cmd.eval      = 1'b1;
         CS_ROOT:   cmd.root_step = 1'b1;
         CS_FINISH: cmd.root_done = 1'b1;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

[src/ffid_dp.sv]
// ----------------------------------------------------------------------------
// ffid_dp
// Datapath: squared magnitude, detector state and counters, bitwise square
// root of the window peak, and the result register.
// ----------------------------------------------------------------------------
module ffid_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  ffid_pkg::dp_cmd_type        cmd,
   output ffid_pkg::dp_sts_type        sts,
   input  ffid_pkg::cfg_type           cfg,
   input  logic [ffid_pkg::REQ_W-1:0]  req_tdata,
   output logic [ffid_pkg::RSP_W-1:0]  rsp_tdata,
   output logic [1:0]                  rsp_tuser
);
   import ffid_pkg::*;

   function automatic logic [15:0] tick_add(input logic [15:0] a);
      logic [16:0] s;
      s = {1'b0, a} + 17'(TICK_MS);
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   // detector state
   phase_type          phase_ff, phase_in;
   logic [15:0]        fall_time_ff, fall_time_in;
   logic [15:0]        window_ff, window_in;
   logic [31:0]        peak_ff, peak_in;
   logic [SLOT_W-1:0]  head_ff, head_in;
   logic [COUNT_W-1:0] fill_ff, fill_in;
   logic [31:0]        falls_ff, falls_in;
   logic [31:0]        impacts_ff, impacts_in;
   logic [15:0]        largest_ff, largest_in;
   logic [15:0]        beep_ff, beep_in;

   // request and working registers
   logic signed [15:0] ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic [31:0]        stamp_ff, stamp_in;
   logic [31:0]        mag_ff, mag_in;
   logic [31:0]        rem_ff, rem_in, root_ff, root_in, bit_ff, bit_in;

   // result fields of this step
   event_type          kind_ff, kind_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [31:0]        etime_ff, etime_in;
   logic [15:0]        edur_ff, edur_in;
   logic [31:0]        psq_ff, psq_in;
   logic [15:0]        proot_ff, proot_in;

   // output register
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;
   event_type          rsp_kind_ff, rsp_kind_in;

   logic signed [15:0] sq_operand;
   logic signed [31:0] sq_prod;
   logic               below, at_impact;
   logic [15:0]        fall_next, window_next;
   logic [31:0]        peak_next, trial;

   always_comb begin
      case (cmd.axis)
         AXIS_X:  sq_operand = ax_ff;
         AXIS_Y:  sq_operand = ay_ff;
         default: sq_operand = az_ff;
      endcase
   end

   assign sq_prod     = sq_operand * sq_operand;
   assign below       = mag_ff < cfg.fall_thr;
   assign at_impact   = mag_ff >= cfg.impact_thr;
   assign fall_next   = tick_add(fall_time_ff);
   assign window_next = tick_add(window_ff);
   assign peak_next   = (mag_ff > peak_ff) ? mag_ff : peak_ff;
   assign trial       = root_ff + bit_ff;
   assign sts.impact  = (phase_ff == PH_IMPACT) && at_impact;

   always_comb begin
      phase_in     = phase_ff;
      fall_time_in = fall_time_ff;
      window_in    = window_ff;
      peak_in      = peak_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      falls_in     = falls_ff;
      impacts_in   = impacts_ff;
      largest_in   = largest_ff;
      beep_in      = beep_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      az_in        = az_ff;
      stamp_in     = stamp_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      kind_in      = kind_ff;
      slot_in      = slot_ff;
      etime_in     = etime_ff;
      edur_in      = edur_ff;
      psq_in       = psq_ff;
      proot_in     = proot_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;

      if (cmd.capture) begin
         ax_in    = req_tdata[15:0];
         ay_in    = req_tdata[31:16];
         az_in    = req_tdata[47:32];
         stamp_in = req_tdata[79:48];
      end

      if (cmd.sq_step) begin
         mag_in = ((cmd.axis == AXIS_X) ? 32'd0 : mag_ff) + $unsigned(sq_prod);
      end

      if (cmd.clear || cmd.eval) begin
         kind_in  = EV_NONE;
         slot_in  = '0;
         etime_in = '0;
         edur_in  = '0;
         psq_in   = '0;
         proot_in = '0;
      end

      if (cmd.clear) begin
         phase_in     = PH_IDLE;
         fall_time_in = '0;
         window_in    = '0;
         peak_in      = '0;
         head_in      = '0;
         fill_in      = '0;
         falls_in     = '0;
         impacts_in   = '0;
         largest_in   = '0;
         beep_in      = '0;
      end

      if (cmd.eval) begin
         beep_in = (beep_ff > 16'(TICK_MS)) ? beep_ff - 16'(TICK_MS) : 16'd0;
         case (phase_ff)
            PH_IDLE: begin
               if (below) begin
                  phase_in     = PH_FALLING;
                  fall_time_in = tick_add(16'd0);
               end
            end
            PH_FALLING: begin
               if (below) begin
                  fall_time_in = fall_next;
                  if (fall_next >= cfg.fall_min) begin
                     falls_in  = falls_ff + 1'b1;
                     kind_in   = EV_FALL;
                     slot_in   = head_ff;
                     etime_in  = stamp_ff;
                     edur_in   = fall_next;
                     head_in   = (head_ff == SLOT_W'(LOG_SLOTS - 1)) ? '0 : head_ff + 1'b1;
                     if (fill_ff < COUNT_W'(LOG_SLOTS)) begin
                        fill_in = fill_ff + 1'b1;
                     end
                     beep_in   = cfg.beep;
                     phase_in  = PH_IMPACT;
                     window_in = '0;
                     peak_in   = '0;
                  end
               end else begin
                  phase_in     = PH_IDLE;
                  fall_time_in = '0;
               end
            end
            PH_IMPACT: begin
               window_in = window_next;
               peak_in   = peak_next;
               if (at_impact) begin
                  // annotate the newest slot, the square root steps follow
                  impacts_in = impacts_ff + 1'b1;
                  kind_in    = EV_IMPACT;
                  slot_in    = (head_ff == '0) ? SLOT_W'(LOG_SLOTS - 1) : head_ff - 1'b1;
                  psq_in     = peak_next;
                  phase_in   = PH_IDLE;
                  rem_in     = peak_next;
                  root_in    = '0;
                  bit_in     = 32'h4000_0000;
               end else if (window_next >= cfg.window) begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      if (cmd.root_step) begin
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end

      if (cmd.root_done) begin
         proot_in = root_ff[15:0];
         if (root_ff[15:0] > largest_ff) begin
            largest_in = root_ff[15:0];
         end
      end

      if (cmd.load_out) begin
         rsp_data_in = {4'd0, largest_ff, impacts_ff, falls_ff, proot_ff, psq_ff,
                        edur_ff, etime_ff, fill_ff, slot_ff, (beep_ff != 16'd0),
                        phase_ff};
         rsp_kind_in = kind_ff;
      end
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         fall_time_ff <= '0;
         window_ff    <= '0;
         peak_ff      <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         falls_ff     <= '0;
         impacts_ff   <= '0;
         largest_ff   <= '0;
         beep_ff      <= '0;
      end else begin
         phase_ff     <= phase_in;
         fall_time_ff <= fall_time_in;
         window_ff    <= window_in;
         peak_ff      <= peak_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         falls_ff     <= falls_in;
         impacts_ff   <= impacts_in;
         largest_ff   <= largest_in;
         beep_ff      <= beep_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      az_ff       <= az_in;
      stamp_ff    <= stamp_in;
      mag_ff      <= mag_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      kind_ff     <= kind_in;
      slot_ff     <= slot_in;
      etime_ff    <= etime_in;
      edur_ff     <= edur_in;
      psq_ff      <= psq_in;
      proot_ff    <= proot_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
   end

endmodule

[src/freefall_impact_detector.sv]
// ----------------------------------------------------------------------------
// freefall_impact_detector
// Free-fall and impact detector: sample in, one status/event result out.
// The squarer works through the three axes on one shared 16x16 multiplier,
// then come the update step and the output load; an impact adds the square
// root, and a clear goes straight to the load. A new request is taken only
// once the last is through, and the load waits while a result is still held.
// Reset clears the detector state and counters and loads the register defaults.
// ----------------------------------------------------------------------------
module freefall_impact_detector (
   input  logic                        clock,
   input  logic                        reset,
   // request stream
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // tdata: accel_x[15:0], accel_y[31:16], accel_z[47:32], time_seconds[79:48]
   input  logic [ffid_pkg::REQ_W-1:0]  req_tdata,
   // tuser: req_type[0]
   input  logic                        req_tuser,
   // result stream
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // tdata: detector_state[1:0], beep_on[2], event_slot[6:3], log_entries[11:7],
   //        event_time[43:12], fall_span_ms[59:44], peak_sq[91:60],
   //        peak_root[107:92], falls_total[139:108], impacts_total[171:140],
   //        largest_impact_root[187:172], zero[191:188]
   output logic [ffid_pkg::RSP_W-1:0]  rsp_tdata,
   // tuser: event_kind[1:0]
   output logic [1:0]                  rsp_tuser,
   // register port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ffid_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [ffid_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [ffid_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import ffid_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       csr_write;
   logic [2:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_FALL_THR:   cfg_in.fall_thr   = csr_pwdata;
            REG_IMPACT_THR: cfg_in.impact_thr = csr_pwdata;
            REG_FALL_MIN:   cfg_in.fall_min   = csr_pwdata[15:0];
            REG_WINDOW:     cfg_in.window     = csr_pwdata[15:0];
            REG_BEEP:       cfg_in.beep       = csr_pwdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_FALL_THR:   csr_prdata = cfg_ff.fall_thr;
         REG_IMPACT_THR: csr_prdata = cfg_ff.impact_thr;
         REG_FALL_MIN:   csr_prdata = {16'd0, cfg_ff.fall_min};
         REG_WINDOW:     csr_prdata = {16'd0, cfg_ff.window};
         REG_BEEP:       csr_prdata = {16'd0, cfg_ff.beep};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fall_thr   <= FALL_THR_RST;
         cfg_ff.impact_thr <= IMPACT_THR_RST;
         cfg_ff.fall_min   <= FALL_MIN_RST;
         cfg_ff.window     <= WINDOW_RST;
         cfg_ff.beep       <= BEEP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ffid_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   ffid_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .cfg       (cfg_ff),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

`ifndef NO_ASSERTIONS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in progress");

   a_fall_opens_window: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EV_FALL) |-> (rsp_tdata[1:0] == PH_IMPACT))
      else $error("fall event without impact window");

   a_impact_ends_window: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EV_IMPACT) |-> (rsp_tdata[1:0] == PH_IDLE))
      else $error("impact event left detector out of idle");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[11:7] <= COUNT_W'(LOG_SLOTS)))
      else $error("log entries beyond log depth");
`endif

endmodule

[sim/freefall_impact_detector_test.sv]
// ----------------------------------------------------------------------------
// freefall_impact_detector_test
// Self-checking bench for the free-fall and impact detector. A built-in
// tracker follows each accepted request and predicts the status result, which
// is compared field by field with what the result stream delivers. Directed
// fall/impact cases and register extremes come first, then result back
// pressure and randomized fall episodes under several register settings.
// ----------------------------------------------------------------------------
module freefall_impact_detector_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ffid_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 30;
   localparam logic [2:0] REG_UNUSED_LO = 3'd5;
   localparam logic [2:0] REG_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } accel_type;

   typedef struct packed {
      logic        clear;
      accel_type   acc;
      logic [31:0] stamp;
   } request_type;

   typedef struct packed {
      phase_type            state;
      logic                 beep_on;
      event_type            kind;
      logic [SLOT_W-1:0]    slot;
      logic [COUNT_W-1:0]   fill;
      logic [31:0]          stamp;
      logic [15:0]          duration;
      logic [31:0]          peak;
      logic [15:0]          root;
      logic [31:0]          falls;
      logic [31:0]          impacts;
      logic [15:0]          largest;
   } result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   // tdata: accel_x[15:0], accel_y[31:16], accel_z[47:32], time_seconds[79:48]
   logic [REQ_W-1:0]    req_tdata = '0;
   // tuser: req_type[0]
   logic                req_tuser = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   // tdata: detector_state, beep_on, event_slot, log_entries, event_time,
   //        fall_span_ms, peak_sq, peak_root, falls_total, impacts_total,
   //        largest_impact_root, zero pad
   logic [RSP_W-1:0]    rsp_tdata;
   // tuser: event_kind[1:0]
   logic [1:0]          rsp_tuser;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   freefall_impact_detector dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // register copy and detector tracking state
   cfg_type             reg_mirror;
   phase_type           track_phase;
   logic [15:0]         fall_ms;
   logic [15:0]         window_ms;
   logic [15:0]         beep_ms;
   logic [15:0]         largest_root;
   logic [31:0]         window_peak;
   logic [31:0]         falls_count;
   logic [31:0]         impacts_count;
   logic [SLOT_W-1:0]   head_slot;
   logic [COUNT_W-1:0]  log_fill;

   result_type          pending_status[$];
   result_type          arrived;
   result_type          awaited;

   int                  error_count = 0;
   int                  items_sent = 0;
   int                  settings_used = 1;
   int                  clears_seen = 0;
   int                  fall_events = 0;
   int                  impact_events = 0;
   int                  cycle_count = 0;
   int                  req_gap_max = 12;
   int                  rsp_stall_max = 12;
   int                  hold_request = 0;
   int                  hold_left = 0;
   int                  stall_left = 0;
   bit                  offering = 1'b0;

   function automatic logic [15:0] int_sqrt(input logic [31:0] n);
      logic [15:0] acc;
      logic [15:0] trial;
      acc = '0;
      for (int b = 15; b >= 0; b--) begin
         trial = acc | (16'd1 << b);
         if (32'(trial) * 32'(trial) <= n)
            acc = trial;
      end
      return acc;
   endfunction

   function automatic logic [15:0] add_tick(input logic [15:0] t);
      int sum;
      sum = int'(t) + TICK_MS;
      return (sum > 16'hFFFF) ? 16'hFFFF : sum[15:0];
   endfunction

   task automatic clear_tracker();
      track_phase = PH_IDLE;
      fall_ms = '0;
      window_ms = '0;
      window_peak = '0;
      head_slot = '0;
      log_fill = '0;
      falls_count = '0;
      impacts_count = '0;
      largest_root = '0;
      beep_ms = '0;
   endtask

   task automatic predict_status(input request_type r, output result_type o);
      longint      mag;
      logic [31:0] level;
      logic [15:0] root;
      o = '0;
      o.kind = EV_NONE;
      if (r.clear) begin
         clear_tracker();
         clears_seen++;
      end else begin
         mag = longint'($signed(r.acc.x)) * longint'($signed(r.acc.x))
             + longint'($signed(r.acc.y)) * longint'($signed(r.acc.y))
             + longint'($signed(r.acc.z)) * longint'($signed(r.acc.z));
         level = (mag > 64'hFFFFFFFF) ? 32'hFFFFFFFF : mag[31:0];
         beep_ms = (beep_ms > 16'(TICK_MS)) ? beep_ms - 16'(TICK_MS) : 16'd0;
         case (track_phase)
            PH_IDLE: begin
               if (level < reg_mirror.fall_thr) begin
                  track_phase = PH_FALLING;
                  fall_ms = add_tick(16'd0);
               end
            end
            PH_FALLING: begin
               if (level < reg_mirror.fall_thr) begin
                  fall_ms = add_tick(fall_ms);
                  if (fall_ms >= reg_mirror.fall_min) begin
                     falls_count++;
                     fall_events++;
                     o.kind = EV_FALL;
                     o.slot = head_slot;
                     o.stamp = r.stamp;
                     o.duration = fall_ms;
                     head_slot = SLOT_W'((head_slot + 1) % LOG_SLOTS);
                     if (log_fill < LOG_SLOTS)
                        log_fill++;
                     beep_ms = reg_mirror.beep;
                     track_phase = PH_IMPACT;
                     window_ms = '0;
                     window_peak = '0;
                  end
               end else begin
                  track_phase = PH_IDLE;
                  fall_ms = '0;
               end
            end
            default: begin
               window_ms = add_tick(window_ms);
               if (level > window_peak)
                  window_peak = level;
               if (level >= reg_mirror.impact_thr) begin
                  root = int_sqrt(window_peak);
                  impacts_count++;
                  impact_events++;
                  if (root > largest_root)
                     largest_root = root;
                  o.kind = EV_IMPACT;
                  o.slot = SLOT_W'((head_slot + LOG_SLOTS - 1) % LOG_SLOTS);
                  o.peak = window_peak;
                  o.root = root;
                  track_phase = PH_IDLE;
               end else if (window_ms >= reg_mirror.window) begin
                  track_phase = PH_IDLE;
               end
            end
         endcase
      end
      o.state = track_phase;
      o.beep_on = (beep_ms != 0);
      o.fill = log_fill;
      o.falls = falls_count;
      o.impacts = impacts_count;
      o.largest = largest_root;
   endtask

   // ---------------------------------------------------------------- samples
   function automatic logic signed [15:0] signed_pick(input int lo, input int hi);
      int v;
      v = $urandom_range(lo, hi);
      return 16'($urandom_range(0, 1) ? -v : v);
   endfunction

   function automatic accel_type axes(input int x, input int y, input int z);
      accel_type a;
      a.x = 16'(x);
      a.y = 16'(y);
      a.z = 16'(z);
      return a;
   endfunction

   // roughly 1 g on one axis with some noise
   function automatic accel_type rest_sample();
      accel_type a;
      a.x = signed_pick(0, 1500);
      a.y = signed_pick(0, 1500);
      a.z = signed_pick(15000, 17500);
      return a;
   endfunction

   // every axis small enough to keep the squared magnitude under the fall threshold
   function automatic accel_type low_sample();
      accel_type a;
      int        lim;
      lim = (reg_mirror.fall_thr == 0) ? 0 : int'(int_sqrt((reg_mirror.fall_thr - 1) / 3));
      if (lim > 32767)
         lim = 32767;
      a.x = signed_pick(0, lim);
      a.y = signed_pick(0, lim);
      a.z = signed_pick(0, lim);
      return a;
   endfunction

   function automatic accel_type high_sample();
      accel_type a;
      a.x = signed_pick(16000, 32768);
      a.y = signed_pick(16000, 32768);
      a.z = signed_pick(16000, 32768);
      return a;
   endfunction

   function automatic accel_type any_sample();
      accel_type a;
      a.x = 16'($urandom());
      a.y = 16'($urandom());
      a.z = 16'($urandom());
      return a;
   endfunction

   // ---------------------------------------------------------------- drivers
   task automatic send_request(input logic clear, input accel_type acc);
      request_type r;
      result_type  o;
      int          gap;
      r.clear = clear;
      r.acc = acc;
      r.stamp = $urandom();
      gap = (req_gap_max == 0) ? 0 : $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         if (offering)
            req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= clear;
      req_tdata <= {r.stamp, acc.z, acc.y, acc.x};
      offering = 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_status(r, o);
      pending_status.push_back(o);
      items_sent++;
   endtask

   task automatic wait_all_results();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
      while (pending_status.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_FALL_THR:   reg_mirror.fall_thr = value;
         REG_IMPACT_THR: reg_mirror.impact_thr = value;
         REG_FALL_MIN:   reg_mirror.fall_min = value[15:0];
         REG_WINDOW:     reg_mirror.window = value[15:0];
         REG_BEEP:       reg_mirror.beep = value[15:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input cfg_type c);
      wait_all_results();
      write_reg(REG_FALL_THR, c.fall_thr);
      write_reg(REG_IMPACT_THR, c.impact_thr);
      write_reg(REG_FALL_MIN, 32'(c.fall_min));
      write_reg(REG_WINDOW, 32'(c.window));
      write_reg(REG_BEEP, 32'(c.beep));
      settings_used++;
   endtask

   // rest, a run of low samples sized to confirm, at most 40 (or broken early),
   // then a few window samples and usually an impact
   task automatic send_episode();
      int need;
      int roll;
      need = (int'(reg_mirror.fall_min) + TICK_MS - 1) / TICK_MS;
      if (need < 2)
         need = 2;
      if (need > 40)
         need = 40;
      repeat ($urandom_range(0, 3)) send_request(1'b0, rest_sample());
      roll = $urandom_range(0, 99);
      if (roll < 4)
         send_request(1'b1, any_sample());
      else if (roll < 14)
         send_request(1'b0, any_sample());
      if ($urandom_range(0, 99) < 15) begin
         repeat ($urandom_range(1, need - 1)) send_request(1'b0, low_sample());
         send_request(1'b0, rest_sample());
      end else begin
         repeat (need) send_request(1'b0, low_sample());
         repeat ($urandom_range(0, 6)) send_request(1'b0, rest_sample());
         if ($urandom_range(0, 9) < 7)
            send_request(1'b0, high_sample());
      end
   endtask

   // ---------------------------------------------------------------- result side
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         hold_left = 0;
      end else begin
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (rsp_tvalid && rsp_tready)
            stall_left = (rsp_stall_max == 0) ? 0 : $urandom_range(0, rsp_stall_max);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_status.size() == 0) begin
            $error("result arrived with no request outstanding");
            error_count++;
         end else begin
            awaited = pending_status.pop_front();
            arrived.state = phase_type'(rsp_tdata[1:0]);
            arrived.beep_on = rsp_tdata[2];
            arrived.slot = rsp_tdata[6:3];
            arrived.fill = rsp_tdata[11:7];
            arrived.stamp = rsp_tdata[43:12];
            arrived.duration = rsp_tdata[59:44];
            arrived.peak = rsp_tdata[91:60];
            arrived.root = rsp_tdata[107:92];
            arrived.falls = rsp_tdata[139:108];
            arrived.impacts = rsp_tdata[171:140];
            arrived.largest = rsp_tdata[187:172];
            arrived.kind = event_type'(rsp_tuser);
            check_field("detector_state", awaited.state, arrived.state);
            check_field("beep_on", awaited.beep_on, arrived.beep_on);
            check_field("event_kind", awaited.kind, arrived.kind);
            check_field("event_slot", awaited.slot, arrived.slot);
            check_field("log_entries", awaited.fill, arrived.fill);
            check_field("event_time", awaited.stamp, arrived.stamp);
            check_field("fall_span_ms", awaited.duration, arrived.duration);
            check_field("peak_sq", awaited.peak, arrived.peak);
            check_field("peak_root", awaited.root, arrived.root);
            check_field("falls_total", awaited.falls, arrived.falls);
            check_field("impacts_total", awaited.impacts, arrived.impacts);
            check_field("largest_impact_root", awaited.largest, arrived.largest);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests
   // reset defaults: rest, an eight-sample fall, full-scale impact, clear
   task automatic test_fall_and_impact();
      send_request(1'b0, axes(0, 0, 16384));
      repeat (8) send_request(1'b0, axes(0, 0, 0));
      send_request(1'b0, axes(-32768, -32768, -32768));
      send_request(1'b0, axes(32767, 32767, 32767));
      send_request(1'b1, any_sample());
   endtask

   task automatic test_register_extremes();
      cfg_type c;
      // two samples confirm a fall, the window closes on its first sample
      c = '{fall_thr: 32'hFFFFFFFF, impact_thr: 32'hFFFFFFFF, fall_min: 16'd0,
            window: 16'd0, beep: 16'hFFFF};
      apply_settings(c);
      // unmapped indexes must leave every register alone
      write_reg(REG_UNUSED_LO, 32'h0);
      write_reg(REG_UNUSED_HI, 32'h0);
      repeat (3) send_request(1'b0, any_sample());
      // every window sample is an impact, even with a zero peak
      c = '{fall_thr: 32'hFFFFFFFF, impact_thr: 32'h0, fall_min: 16'd0,
            window: 16'hFFFF, beep: 16'd0};
      apply_settings(c);
      repeat (3) send_request(1'b0, axes(0, 0, 0));
      // nothing is below a zero threshold
      wait_all_results();
      write_reg(REG_FALL_THR, 32'h0);
      send_request(1'b0, axes(0, 0, 0));
   endtask

   // results held back long enough that the block stalls its input
   task automatic test_result_stall();
      cfg_type c;
      c = '{fall_thr: FALL_THR_RST, impact_thr: IMPACT_THR_RST, fall_min: FALL_MIN_RST,
            window: WINDOW_RST, beep: BEEP_RST};
      apply_settings(c);
      req_gap_max = 0;
      rsp_stall_max = 0;
      hold_request = 400;
      repeat (3) send_episode();
   endtask

   task automatic test_random_episodes();
      cfg_type c;
      int      budget;
      int      target;
      int      midpoint;
      bit      paused;
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin
               c = '{fall_thr: FALL_THR_RST, impact_thr: IMPACT_THR_RST,
                     fall_min: FALL_MIN_RST, window: WINDOW_RST, beep: BEEP_RST};
               req_gap_max = 12;
               rsp_stall_max = 12;
               budget = 180;
            end
            1: begin
               c.fall_thr = $urandom_range(4000000, 60000000);
               c.impact_thr = $urandom_range(200000000, 32'h80000000);
               c.fall_min = 16'($urandom_range(0, 60));
               c.window = 16'($urandom_range(0, 300));
               c.beep = 16'($urandom_range(0, 400));
               req_gap_max = 0;
               rsp_stall_max = 0;
               budget = 130;
            end
            2: begin
               c = '{fall_thr: 32'hFFFFFFFF, impact_thr: $urandom_range(0, 32'hC0000000),
                     fall_min: 16'd10, window: 16'hFFFF, beep: 16'hFFFF};
               req_gap_max = 12;
               rsp_stall_max = 3;
               budget = 130;
            end
            3: begin
               c.fall_thr = FALL_THR_RST;
               c.impact_thr = 32'h0;
               c.fall_min = 16'($urandom_range(0, 100));
               c.window = 16'($urandom_range(0, 100));
               c.beep = 16'($urandom_range(0, 300));
               req_gap_max = 3;
               rsp_stall_max = 12;
               budget = 110;
            end
            4: begin
               c.fall_thr = $urandom();
               c.impact_thr = $urandom();
               c.fall_min = ($urandom_range(0, 1) != 0) ? 16'($urandom()) : 16'($urandom_range(0, 200));
               c.window = 16'($urandom());
               c.beep = 16'($urandom());
               req_gap_max = 12;
               rsp_stall_max = 12;
               budget = 130;
            end
            default: begin
               c.fall_thr = 32'h0;
               c.impact_thr = IMPACT_THR_RST;
               c.fall_min = 16'd0;
               c.window = WINDOW_RST;
               c.beep = BEEP_RST;
               budget = 60;
            end
         endcase
         apply_settings(c);
         target = items_sent + budget;
         midpoint = items_sent + budget / 2;
         paused = 1'b0;
         while (items_sent < target) begin
            // hold the sender until everything in flight has come back
            if (p == 0 && !paused && items_sent >= midpoint) begin
               wait_all_results();
               paused = 1'b1;
            end
            send_episode();
         end
      end
   endtask

   initial begin
      reg_mirror = '{fall_thr: FALL_THR_RST, impact_thr: IMPACT_THR_RST,
                     fall_min: FALL_MIN_RST, window: WINDOW_RST, beep: BEEP_RST};
      clear_tracker();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_fall_and_impact();
      test_register_extremes();
      test_result_stall();
      test_random_episodes();
      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d requests (%0d clears) under %0d register settings",
               items_sent, clears_seen, settings_used);
      $display("Confirmed %0d falls and %0d impacts, with a long result stall and a drain pause",
               fall_events, impact_events);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
